// File: hdl/rmwf_pkg.sv
// ----------------------------------------------------------------------------
// RGB median window filter package
// Shared types, register indexes and default sizes for the median filter.
// ----------------------------------------------------------------------------
package rmwf_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_RADIUS_DEF = 2;
    localparam int HEIGHT_LIMIT   = 4096;
    localparam int OUT_FIFO_DEPTH = 8;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_FRAME_WIDTH   = 2'd0;
    localparam cfg_index_t REG_FRAME_HEIGHT  = 2'd1;
    localparam cfg_index_t REG_WINDOW_RADIUS = 2'd2;

    localparam logic [10:0] WIDTH_RESET  = 11'd640;
    localparam logic [12:0] HEIGHT_RESET = 13'd480;
    localparam logic [1:0]  RADIUS_RESET = 2'd1;

    localparam logic ACTION_DRAIN = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } pix_in_t;

    typedef struct packed {
        logic [7:0]  out_red;
        logic [7:0]  out_green;
        logic [7:0]  out_blue;
        logic [9:0]  out_column;
        logic [11:0] out_row;
        logic        frame_done;
    } pix_out_t;

    typedef struct packed {
        cfg_index_t            index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [9:0]  column;
        logic [11:0] row;
        logic        done;
    } res_meta_t;

endpackage

// File: hdl/rmwf_stream_if.sv
// ----------------------------------------------------------------------------
// Stream channel interface
// Valid/ready channel carrying one payload per beat.
// ----------------------------------------------------------------------------
interface rmwf_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/rmwf_window_gen.sv
// ----------------------------------------------------------------------------
// Window generator
// Line memories delay the pixel stream by whole rows; a register grid holds
// the last columns so that the full square window is visible at once.
// ----------------------------------------------------------------------------
module rmwf_window_gen
    import rmwf_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic [$clog2(MAX_WIDTH)-1:0] addr,
    input  rgb_t                         px,
    output rgb_t                         win [2*MAX_RADIUS+1][2*MAX_RADIUS+1]
);

    localparam int TAPS     = 2 * MAX_RADIUS;
    localparam int WIN_SIDE = TAPS + 1;
    localparam int COL_W    = $clog2(MAX_WIDTH);

    logic             step_reg;
    logic [COL_W-1:0] addr_reg;
    rgb_t             px_reg;
    rgb_t             tap_rd  [TAPS];
    rgb_t             wr_data [TAPS];
    rgb_t             col_vec [WIN_SIDE];
    rgb_t             win_reg [WIN_SIDE][WIN_SIDE];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            addr_reg <= addr;
            px_reg   <= px;
        end
    end

    always_comb
    begin
        col_vec[0] = px_reg;
        for (int k = 0; k < TAPS; k++)
        begin
            wr_data[k]   = (k == 0) ? px_reg : tap_rd[(k == 0) ? 0 : k - 1];
            col_vec[k+1] = tap_rd[k];
        end
    end

    // One row memory per tap; a read that meets the write of the same
    // column in the same cycle takes the data being written.
    for (genvar g = 0; g < TAPS; g++)
    begin : g_tap
        rgb_t line_mem [MAX_WIDTH];
        rgb_t rd_reg;

        always_ff @(posedge clk)
        begin
            if (step_reg)
            begin
                line_mem[addr_reg] <= wr_data[g];
            end
            if (step)
            begin
                if (step_reg && (addr_reg == addr))
                begin
                    rd_reg <= wr_data[g];
                end
                else
                begin
                    rd_reg <= line_mem[addr];
                end
            end
        end

        assign tap_rd[g] = rd_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step_reg)
        begin
            for (int k = 0; k < WIN_SIDE; k++)
            begin
                win_reg[k][0] <= col_vec[k];
                for (int j = 1; j < WIN_SIDE; j++)
                begin
                    win_reg[k][j] <= win_reg[k][j-1];
                end
            end
        end
    end

    assign win = win_reg;

endmodule

// File: hdl/rmwf_median_lane.sv
// ----------------------------------------------------------------------------
// Median lane
// Rank selection over one color channel of the window in three stages:
// pairwise compare, rank match, select.
// ----------------------------------------------------------------------------
module rmwf_median_lane
    import rmwf_pkg::*;
#(
    parameter int N = 25
) (
    input  logic                     clk,
    input  logic [7:0]               vals  [N],
    input  logic [N-1:0]             mask,
    input  logic [$clog2(N+1)-1:0]   half,
    output logic [7:0]               median
);

    localparam int CNT_W = $clog2(N + 1);

    logic [N-1:0]     less_a [N];
    logic [7:0]       vals_a [N];
    logic [N-1:0]     mask_a;
    logic [CNT_W-1:0] half_a;
    logic [N-1:0]     sel_b;
    logic [7:0]       vals_b [N];
    logic [7:0]       med_reg;
    logic [7:0]       med_next;

    // Ties are broken by position, so the ranks of the valid entries are
    // all distinct and exactly one of them equals half the count.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < N; i++)
        begin
            for (int j = 0; j < N; j++)
            begin
                less_a[i][j] <= mask[j] && ((vals[j] < vals[i]) ||
                                ((vals[j] == vals[i]) && (j < i)));
            end
        end
        vals_a <= vals;
        mask_a <= mask;
        half_a <= half;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < N; i++)
        begin
            sel_b[i] <= mask_a[i] && (CNT_W'($countones(less_a[i])) == half_a);
        end
        vals_b <= vals_a;
    end

    always_comb
    begin
        med_next = 8'd0;
        for (int i = 0; i < N; i++)
        begin
            med_next = med_next | (sel_b[i] ? vals_b[i] : 8'd0);
        end
    end

    always_ff @(posedge clk)
    begin
        med_reg <= med_next;
    end

    assign median = med_reg;

endmodule

// File: hdl/rmwf_out_fifo.sv
// ----------------------------------------------------------------------------
// Result queue
// Small queue that decouples the free-running pipeline from the sink.
// ----------------------------------------------------------------------------
module rmwf_out_fifo
    import rmwf_pkg::*;
#(
    parameter int DEPTH = OUT_FIFO_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  pix_out_t                   push_data,
    output logic [$clog2(DEPTH+1)-1:0] count,
    rmwf_stream_if.source              out
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pix_out_t         mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             pop;

    assign pop         = out.valid && out.ready;
    assign out.valid   = (count_reg != '0);
    assign out.payload = mem[rd_ptr_reg];
    assign count       = count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: hdl/rgb_median_window_filter_unit.sv
// ----------------------------------------------------------------------------
// RGB median window filter unit
// Per-channel median over a square window around each pixel of a raster
// stream, with the window clipped at the image borders.
// ----------------------------------------------------------------------------
//
//   channel  | dir | beat contents
//   ---------+-----+-----------------------------------------------
//   pixel    | in  | action, in_red, in_green, in_blue
//   result   | out | medians, out_column, out_row, frame_done
//   cfg      | in  | register index, write data (always ready)
//
// One pixel beat is taken every clock while pixel ready is high. The line memory
// read happens at the accepting edge; the beat that completes a window then passes
// the window grid, the three stages of each median lane and the write into the
// result queue before its result leaves.
// Reset returns the registers to 640 by 480 with radius 1 and restarts the
// frame; a register write also restarts the frame and holds pixel ready low
// for one cycle while the frame size products settle.
// A stalled result sink fills the result queue; outside the settle cycle pixel
// ready drops only when the queue and in-flight results would overflow it.
// ----------------------------------------------------------------------------
module rgb_median_window_filter_unit
    import rmwf_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    rmwf_stream_if.sink   pixel,
    rmwf_stream_if.source result,
    rmwf_stream_if.sink   cfg
);

    localparam int WIN_SIDE   = 2 * MAX_RADIUS + 1;
    localparam int WIN_N      = WIN_SIDE * WIN_SIDE;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int W_EFF      = (MAX_WIDTH < 2047) ? MAX_WIDTH : 2047;
    localparam int LIN_W      = $clog2(W_EFF * (HEIGHT_LIMIT + MAX_RADIUS + 1));
    localparam int CNT_W      = $clog2(WIN_N + 1);
    localparam int RAD_W      = $clog2(MAX_RADIUS + 1);
    localparam int FCNT_W     = $clog2(OUT_FIFO_DEPTH + 1);
    localparam int LANE_DEPTH = 3;

    // Configuration registers and the values actually used.
    logic [10:0]      width_reg;
    logic [12:0]      height_reg;
    logic [1:0]       radius_reg;
    logic [10:0]      w_used;
    logic [12:0]      h_used;
    logic [RAD_W-1:0] r_used;

    // Frame size products, recomputed every cycle from the registers.
    logic [LIN_W-1:0] total_reg;
    logic [LIN_W-1:0] last_reg;
    logic [LIN_W-1:0] lag_reg;

    // Stream position counters.
    logic [LIN_W-1:0] t_reg;
    logic [COL_W-1:0] in_col_reg;
    logic [LIN_W-1:0] q_reg;
    logic [COL_W-1:0] out_col_reg;
    logic [11:0]      out_row_reg;
    logic             complete_reg;
    logic             settle_reg;

    logic accept;
    logic has_px;
    logic step;
    logic emit;
    logic last_out;
    logic cfg_acc;
    logic restart;
    rgb_t px_in;

    logic [WIN_SIDE-1:0] row_ok;
    logic [WIN_SIDE-1:0] col_ok;
    logic [WIN_N-1:0]    mask_now;
    logic [CNT_W-1:0]    half_now;
    res_meta_t           meta_now;

    // Stage registers between the accept stage and the lanes.
    logic             s1_emit_reg;
    logic             s2_emit_reg;
    res_meta_t        s1_meta_reg;
    res_meta_t        s2_meta_reg;
    logic [WIN_N-1:0] s1_mask_reg;
    logic [WIN_N-1:0] s2_mask_reg;
    logic [CNT_W-1:0] s1_half_reg;
    logic [CNT_W-1:0] s2_half_reg;
    logic             lv_reg   [LANE_DEPTH];
    res_meta_t        lmeta_reg[LANE_DEPTH];

    rgb_t        win [WIN_SIDE][WIN_SIDE];
    logic [7:0]  red_vals   [WIN_N];
    logic [7:0]  green_vals [WIN_N];
    logic [7:0]  blue_vals  [WIN_N];
    logic [7:0]  red_med;
    logic [7:0]  green_med;
    logic [7:0]  blue_med;
    pix_out_t    merged;
    logic [FCNT_W-1:0] fifo_count;
    logic [LANE_DEPTH+1:0] inflight_bits;

    // ------------------------------------------------------------------
    // Register clamping: a zero size counts as one, oversize is capped.
    // ------------------------------------------------------------------
    always_comb
    begin
        if (width_reg == 11'd0)
        begin
            w_used = 11'd1;
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            w_used = 11'(MAX_WIDTH);
        end
        else
        begin
            w_used = width_reg;
        end

        if (height_reg == 13'd0)
        begin
            h_used = 13'd1;
        end
        else if (32'(height_reg) > HEIGHT_LIMIT)
        begin
            h_used = 13'(HEIGHT_LIMIT);
        end
        else
        begin
            h_used = height_reg;
        end

        if (32'(radius_reg) > MAX_RADIUS)
        begin
            r_used = RAD_W'(MAX_RADIUS);
        end
        else
        begin
            r_used = RAD_W'(radius_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg <= LIN_W'(32'(w_used) * 32'(h_used));
        last_reg  <= LIN_W'(32'(w_used) * 32'(h_used) - 32'd1);
        lag_reg   <= LIN_W'(32'(r_used) * 32'(w_used) + 32'(r_used));
    end

    // ------------------------------------------------------------------
    // Accept stage. A drain beat before the last pixel is dropped, a pixel
    // after the last one counts as a drain step, and once the final result
    // is out every beat is dropped until the next restart.
    // ------------------------------------------------------------------
    assign cfg.ready     = 1'b1;
    assign cfg_acc       = cfg.valid && cfg.ready;
    assign inflight_bits = {s1_emit_reg, s2_emit_reg, lv_reg[0], lv_reg[1], lv_reg[2]};
    assign pixel.ready   = !settle_reg &&
                           ((32'($countones(inflight_bits)) + 32'(fifo_count)) <
                            OUT_FIFO_DEPTH);

    assign accept   = pixel.valid && pixel.ready;
    assign has_px   = (t_reg < total_reg);
    assign step     = accept && !complete_reg &&
                      !(has_px && (pixel.payload.action == ACTION_DRAIN));
    assign emit     = step && (t_reg >= lag_reg);
    assign last_out = (q_reg == last_reg);

    assign px_in.red   = pixel.payload.in_red;
    assign px_in.green = pixel.payload.in_green;
    assign px_in.blue  = pixel.payload.in_blue;

    always_comb
    begin
        restart = 1'b0;
        if (cfg_acc)
        begin
            unique case (cfg.payload.index)
                REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_WINDOW_RADIUS: restart = 1'b1;
                default: restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            radius_reg <= RADIUS_RESET;
        end
        else if (cfg_acc)
        begin
            unique case (cfg.payload.index)
                REG_FRAME_WIDTH:   width_reg  <= cfg.payload.data[10:0];
                REG_FRAME_HEIGHT:  height_reg <= cfg.payload.data[12:0];
                REG_WINDOW_RADIUS: radius_reg <= cfg.payload.data[1:0];
                default:           width_reg  <= width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_reg        <= '0;
            in_col_reg   <= '0;
            q_reg        <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            complete_reg <= 1'b0;
            settle_reg   <= 1'b1;
        end
        else
        begin
            settle_reg <= cfg_acc;
            if (restart)
            begin
                t_reg        <= '0;
                in_col_reg   <= '0;
                q_reg        <= '0;
                out_col_reg  <= '0;
                out_row_reg  <= '0;
                complete_reg <= 1'b0;
            end
            else
            begin
                if (step)
                begin
                    t_reg <= t_reg + 1'b1;
                    if ((32'(in_col_reg) + 32'd1) >= 32'(w_used))
                    begin
                        in_col_reg <= '0;
                    end
                    else
                    begin
                        in_col_reg <= in_col_reg + 1'b1;
                    end
                end
                if (emit)
                begin
                    q_reg <= q_reg + 1'b1;
                    if (last_out)
                    begin
                        complete_reg <= 1'b1;
                    end
                    if ((32'(out_col_reg) + 32'd1) >= 32'(w_used))
                    begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_reg + 1'b1;
                    end
                    else
                    begin
                        out_col_reg <= out_col_reg + 1'b1;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Border mask. Window row k holds the pixel k rows above the newest one,
    // so it maps to image row (center row + radius - k); columns alike.
    // ------------------------------------------------------------------
    always_comb
    begin
        logic signed [15:0] rr;
        logic signed [15:0] cc;
        for (int k = 0; k < WIN_SIDE; k++)
        begin
            rr = 16'(out_row_reg) + 16'(r_used) - 16'(k);
            cc = 16'(out_col_reg) + 16'(r_used) - 16'(k);
            row_ok[k] = (32'(k) <= 2 * 32'(r_used)) && (rr >= 0) &&
                        (rr < $signed(16'(h_used)));
            col_ok[k] = (32'(k) <= 2 * 32'(r_used)) && (cc >= 0) &&
                        (cc < $signed(16'(w_used)));
        end
        for (int k = 0; k < WIN_SIDE; k++)
        begin
            for (int j = 0; j < WIN_SIDE; j++)
            begin
                mask_now[k*WIN_SIDE+j] = row_ok[k] && col_ok[j];
            end
        end
        half_now = CNT_W'((32'($countones(row_ok)) * 32'($countones(col_ok))) >> 1);
    end

    assign meta_now.column = 10'(out_col_reg);
    assign meta_now.row    = out_row_reg;
    assign meta_now.done   = last_out;

    // ------------------------------------------------------------------
    // Window generation: line memories plus the column grid.
    // ------------------------------------------------------------------
    rmwf_window_gen #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_window_gen (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .addr  (in_col_reg),
        .px    (px_in),
        .win   (win)
    );

    // Control and metadata follow the window through the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_emit_reg <= 1'b0;
            s2_emit_reg <= 1'b0;
            for (int s = 0; s < LANE_DEPTH; s++)
            begin
                lv_reg[s] <= 1'b0;
            end
        end
        else
        begin
            s1_emit_reg <= emit;
            s2_emit_reg <= s1_emit_reg;
            lv_reg[0]   <= s2_emit_reg;
            for (int s = 1; s < LANE_DEPTH; s++)
            begin
                lv_reg[s] <= lv_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_meta_reg  <= meta_now;
        s1_mask_reg  <= mask_now;
        s1_half_reg  <= half_now;
        s2_meta_reg  <= s1_meta_reg;
        s2_mask_reg  <= s1_mask_reg;
        s2_half_reg  <= s1_half_reg;
        lmeta_reg[0] <= s2_meta_reg;
        for (int s = 1; s < LANE_DEPTH; s++)
        begin
            lmeta_reg[s] <= lmeta_reg[s-1];
        end
    end

    // ------------------------------------------------------------------
    // Three channel lanes run side by side on the same window.
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int k = 0; k < WIN_SIDE; k++)
        begin
            for (int j = 0; j < WIN_SIDE; j++)
            begin
                red_vals[k*WIN_SIDE+j]   = win[k][j].red;
                green_vals[k*WIN_SIDE+j] = win[k][j].green;
                blue_vals[k*WIN_SIDE+j]  = win[k][j].blue;
            end
        end
    end

    rmwf_median_lane #(.N(WIN_N)) u_lane_red (
        .clk    (clk),
        .vals   (red_vals),
        .mask   (s2_mask_reg),
        .half   (s2_half_reg),
        .median (red_med)
    );

    rmwf_median_lane #(.N(WIN_N)) u_lane_green (
        .clk    (clk),
        .vals   (green_vals),
        .mask   (s2_mask_reg),
        .half   (s2_half_reg),
        .median (green_med)
    );

    rmwf_median_lane #(.N(WIN_N)) u_lane_blue (
        .clk    (clk),
        .vals   (blue_vals),
        .mask   (s2_mask_reg),
        .half   (s2_half_reg),
        .median (blue_med)
    );

    // Merge: the lane medians join the position and end-of-frame flag.
    always_comb
    begin
        merged.out_red    = red_med;
        merged.out_green  = green_med;
        merged.out_blue   = blue_med;
        merged.out_column = lmeta_reg[LANE_DEPTH-1].column;
        merged.out_row    = lmeta_reg[LANE_DEPTH-1].row;
        merged.frame_done = lmeta_reg[LANE_DEPTH-1].done;
    end

    rmwf_out_fifo #(.DEPTH(OUT_FIFO_DEPTH)) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (lv_reg[LANE_DEPTH-1]),
        .push_data (merged),
        .count     (fifo_count),
        .out       (result)
    );

endmodule
